@@ rtl/core/sorted_timer_event_queue_unit_macros.svh @@
// Assertion macros for the sorted timer event queue checker
`ifndef SORTED_TIMER_EVENT_QUEUE_UNIT_MACROS_SVH
`define SORTED_TIMER_EVENT_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge
`define STQ_ASSERT_NOW(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge
`define STQ_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

@@ rtl/core/stq_pkg.sv @@
// Types and constants of the sorted timer event queue
package stq_pkg;

   localparam int DEPTH_DEF     = 16;
   localparam int TAG_WIDTH_DEF = 16;
   localparam int TIME_WIDTH    = 32;
   localparam int OP_WIDTH      = 2;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_ADD   = 2'd0,
      OP_FIRE  = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD_RD,
      ST_ADD_CMP,
      ST_FIRE_RD,
      ST_FIRE_CMP
   } state_type;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

endpackage

@@ rtl/core/stq_entry_ram.sv @@
// Entry store of the timer queue: one write port, one registered read port
module stq_entry_ram #(
   parameter int DEPTH = stq_pkg::DEPTH_DEF,
   parameter int WIDTH = stq_pkg::TIME_WIDTH + stq_pkg::TAG_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/sorted_timer_event_queue_unit.sv @@
// Sorted timer event queue: circular entry store kept in ascending due-time order
// Add: from the tail, each later entry is read and moved up one slot, then the event is written.
// Add to a full queue, clear and unused codes: result in the cycle after the transfer.
// Fire: pops each head entry due before the now tick; one result per popped event, else one empty result.
// busy covers the whole insert or pop walk; the result strobe cannot be stalled.
// Synchronous reset empties the queue at once; stored entries are not cleared.
module sorted_timer_event_queue_unit #(
   parameter int DEPTH     = stq_pkg::DEPTH_DEF,
   parameter int TAG_WIDTH = stq_pkg::TAG_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [stq_pkg::OP_WIDTH-1:0]     req_operation,
   input  logic [stq_pkg::TIME_WIDTH-1:0]   req_event_time,
   input  logic [TAG_WIDTH-1:0]             req_handler_tag,
   input  logic [stq_pkg::TIME_WIDTH-1:0]   req_now_tick,
   output logic                             rsp_valid,
   output logic                             rsp_fired,
   output logic [TAG_WIDTH-1:0]             rsp_fired_tag,
   output logic                             rsp_status,
   output logic                             rsp_last,
   output logic [$clog2(DEPTH+1)-1:0]       rsp_occupancy
);

   import stq_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;
   localparam int EW = TIME_WIDTH + TAG_WIDTH;

   function automatic logic [PW-1:0] wrap_idx(input logic [PW-1:0] base,
                                             input logic [CW-1:0] ofs);
      logic [SW-1:0] sum;
      sum = SW'(base) + SW'(ofs);
      if (sum >= SW'(DEPTH)) begin
         sum = sum - SW'(DEPTH);
      end
      return sum[PW-1:0];
   endfunction

   state_type               state_ff, state_in;
   logic [PW-1:0]           head_ff, head_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           idx_ff, idx_in;
   logic [TIME_WIDTH-1:0]   time_ff, time_in;
   logic [TAG_WIDTH-1:0]    tag_ff, tag_in;
   logic [TIME_WIDTH-1:0]   now_ff, now_in;
   logic                    pend_valid_ff, pend_valid_in;
   logic [TAG_WIDTH-1:0]    pend_tag_ff, pend_tag_in;
   logic [CW-1:0]           pend_occ_ff, pend_occ_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_fired_ff, rsp_fired_in;
   logic [TAG_WIDTH-1:0]    rsp_tag_ff, rsp_tag_in;
   logic                    rsp_status_ff, rsp_status_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic [CW-1:0]           rsp_occ_ff, rsp_occ_in;

   logic                    ram_we;
   logic [PW-1:0]           ram_waddr;
   logic [EW-1:0]           ram_wdata;
   logic                    ram_re;
   logic [PW-1:0]           ram_raddr;
   logic [EW-1:0]           ram_rdata;

   logic                    accept;
   logic                    full;
   logic [TIME_WIDTH-1:0]   rd_time;
   logic [TAG_WIDTH-1:0]    rd_tag;
   logic [CW-1:0]           idx_dec;
   logic                    move_up;
   logic                    head_due;
   op_type                  req_op;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign full     = (count_ff == CW'(DEPTH));
   assign req_op   = op_type'(req_operation);
   assign rd_time  = ram_rdata[EW-1:TAG_WIDTH];
   assign rd_tag   = ram_rdata[TAG_WIDTH-1:0];
   assign idx_dec  = idx_ff - CW'(1);
   // Entry below the insert slot moves up while it belongs after the new event;
   // the head only yields to a strictly earlier event.
   assign move_up  = (idx_dec != '0) ? (time_ff <= rd_time) : (time_ff < rd_time);
   assign head_due = (rd_time < now_ff);

   stq_entry_ram #(
      .DEPTH (DEPTH),
      .WIDTH (EW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_op == OP_ADD && !full) begin
               state_in = ST_ADD_RD;
            end else if (accept && req_op == OP_FIRE) begin
               state_in = ST_FIRE_RD;
            end
         end
         ST_ADD_RD: begin
            state_in = (idx_ff == '0) ? ST_IDLE : ST_ADD_CMP;
         end
         ST_ADD_CMP: begin
            state_in = move_up ? ST_ADD_RD : ST_IDLE;
         end
         ST_FIRE_RD: begin
            state_in = (count_ff == '0) ? ST_IDLE : ST_FIRE_CMP;
         end
         ST_FIRE_CMP: begin
            state_in = head_due ? ST_FIRE_RD : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      time_in       = time_ff;
      tag_in        = tag_ff;
      now_in        = now_ff;
      pend_valid_in = pend_valid_ff;
      pend_tag_in   = pend_tag_ff;
      pend_occ_in   = pend_occ_ff;
      rsp_valid_in  = 1'b0;
      rsp_fired_in  = rsp_fired_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_occ_in    = rsp_occ_ff;
      ram_we        = 1'b0;
      ram_waddr     = head_ff;
      ram_wdata     = {time_ff, tag_ff};
      ram_re        = 1'b0;
      ram_raddr     = head_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               time_in       = req_event_time;
               tag_in        = req_handler_tag;
               now_in        = req_now_tick;
               idx_in        = count_ff;
               pend_valid_in = 1'b0;
               rsp_fired_in  = 1'b0;
               rsp_tag_in    = '0;
               rsp_status_in = STATUS_OK;
               rsp_last_in   = 1'b1;
               rsp_occ_in    = count_ff;
               case (req_op)
                  OP_ADD: begin
                     if (full) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_FULL;
                     end
                  end
                  OP_FIRE: begin
                  end
                  OP_CLEAR: begin
                     count_in     = '0;
                     rsp_valid_in = 1'b1;
                     rsp_occ_in   = '0;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_ADD_RD: begin
            if (idx_ff == '0) begin
               ram_we        = 1'b1;
               ram_waddr     = head_ff;
               count_in      = count_ff + CW'(1);
               rsp_valid_in  = 1'b1;
               rsp_fired_in  = 1'b0;
               rsp_tag_in    = '0;
               rsp_status_in = STATUS_OK;
               rsp_last_in   = 1'b1;
               rsp_occ_in    = count_ff + CW'(1);
            end else begin
               ram_re    = 1'b1;
               ram_raddr = wrap_idx(head_ff, idx_dec);
            end
         end
         ST_ADD_CMP: begin
            ram_we    = 1'b1;
            ram_waddr = wrap_idx(head_ff, idx_ff);
            if (move_up) begin
               ram_wdata = ram_rdata;
               idx_in    = idx_dec;
            end else begin
               count_in      = count_ff + CW'(1);
               rsp_valid_in  = 1'b1;
               rsp_fired_in  = 1'b0;
               rsp_tag_in    = '0;
               rsp_status_in = STATUS_OK;
               rsp_last_in   = 1'b1;
               rsp_occ_in    = count_ff + CW'(1);
            end
         end
         ST_FIRE_RD: begin
            if (count_ff == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_last_in   = 1'b1;
               rsp_fired_in  = pend_valid_ff;
               rsp_tag_in    = pend_valid_ff ? pend_tag_ff : '0;
               rsp_occ_in    = pend_valid_ff ? pend_occ_ff : count_ff;
               pend_valid_in = 1'b0;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = head_ff;
            end
         end
         ST_FIRE_CMP: begin
            if (head_due) begin
               // Hold the popped tag until the next head shows whether it is the last
               head_in       = wrap_idx(head_ff, CW'(1));
               count_in      = count_ff - CW'(1);
               pend_valid_in = 1'b1;
               pend_tag_in   = rd_tag;
               pend_occ_in   = count_ff - CW'(1);
               if (pend_valid_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_fired_in  = 1'b1;
                  rsp_tag_in    = pend_tag_ff;
                  rsp_status_in = STATUS_OK;
                  rsp_last_in   = 1'b0;
                  rsp_occ_in    = pend_occ_ff;
               end
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_last_in   = 1'b1;
               rsp_fired_in  = pend_valid_ff;
               rsp_tag_in    = pend_valid_ff ? pend_tag_ff : '0;
               rsp_occ_in    = pend_valid_ff ? pend_occ_ff : count_ff;
               pend_valid_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      time_ff       <= time_in;
      tag_ff        <= tag_in;
      now_ff        <= now_in;
      pend_tag_ff   <= pend_tag_in;
      pend_occ_ff   <= pend_occ_in;
      rsp_fired_ff  <= rsp_fired_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_fired     = rsp_fired_ff;
   assign rsp_fired_tag = rsp_tag_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_occupancy = rsp_occ_ff;

endmodule

@@ rtl/core/stq_checker.sv @@
// Port-level checks of the sorted timer event queue, bound to the top level
`include "sorted_timer_event_queue_unit_macros.svh"

module stq_checker #(
   parameter int DEPTH     = stq_pkg::DEPTH_DEF,
   parameter int TAG_WIDTH = stq_pkg::TAG_WIDTH_DEF
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic                             rsp_valid,
   input logic                             rsp_fired,
   input logic [TAG_WIDTH-1:0]             rsp_fired_tag,
   input logic                             rsp_status,
   input logic                             rsp_last,
   input logic [$clog2(DEPTH+1)-1:0]       rsp_occupancy
);

   import stq_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   logic no_fire_rsp;
   assign no_fire_rsp = rsp_valid && !rsp_fired;

   // A result only follows a transfer or work already under way
   `STQ_ASSERT_NOW(a_rsp_has_cause, clock, reset, rsp_valid, $past(busy || start), "result without a transfer")

   // A result without a popped event closes its item and carries no tag
   `STQ_ASSERT_NOW(a_idle_rsp_shape, clock, reset, no_fire_rsp, rsp_last && (rsp_fired_tag == '0), "non-fire result not last or tag set")

   // A dropped add never carries a tag and always ends its item
   `STQ_ASSERT_NOW(a_full_shape, clock, reset, rsp_valid && (rsp_status == STATUS_FULL), rsp_last && !rsp_fired && (rsp_occupancy == CW'(DEPTH)), "bad dropped-add result")

   // More results are pending, so the block stays busy
   `STQ_ASSERT_NOW(a_more_busy, clock, reset, rsp_valid && !rsp_last, busy, "idle before last result")

endmodule

bind sorted_timer_event_queue_unit stq_checker #(
   .DEPTH     (DEPTH),
   .TAG_WIDTH (TAG_WIDTH)
) u_stq_checker (.*);
